// File: src/vfa_pkg.sv
// Shared types, opcodes and saturation helper for the four-component vector ALU.
// No dependencies; every other file in src imports this package.
package vfa_pkg;

  // Width used for every intermediate sum before it is clamped to 32 bits.
  localparam int unsigned SAT_W = 68;

  // Stages of the integer square root, one result bit per stage.
  localparam int unsigned SQRT_STEPS = 32;

  typedef logic signed [SAT_W-1:0] sw_t;

  typedef enum logic [3:0] {
    OP_COPY      = 4'd0,
    OP_ADD       = 4'd1,
    OP_SUB       = 4'd2,
    OP_SCALE     = 4'd3,
    OP_DOT       = 4'd4,
    OP_LENGTH    = 4'd5,
    OP_NORMALIZE = 4'd6,
    OP_MIN       = 4'd7,
    OP_MAX       = 4'd8,
    OP_REFLECT   = 4'd9,
    OP_CROSS     = 4'd10
  } op_t;

  localparam sw_t SAT_HI = {{(SAT_W-31){1'b0}}, {31{1'b1}}};
  localparam sw_t SAT_LO = {{(SAT_W-31){1'b1}}, {31{1'b0}}};
  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  // A clamped 32-bit value and whether clamping took place.
  typedef struct packed {
    logic        flag;
    logic [31:0] val;
  } sat_t;

  // Word passed from the front end through the root and divider stages.
  typedef struct packed {
    op_t              op;
    logic [3:0][31:0] r;
    logic [31:0]      scalar;
    logic             fault;
    logic [3:0][31:0] mag;
    logic [3:0]       neg;
  } pl_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic sat_t sat32(input sw_t v);
    sat_t s;
    if (v > SAT_HI) begin
      s = '{flag: 1'b1, val: S32_MAX};
    end else if (v < SAT_LO) begin
      s = '{flag: 1'b1, val: S32_MIN};
    end else begin
      s = '{flag: 1'b0, val: v[31:0]};
    end
    return s;
  endfunction

endpackage

// File: src/vfa_lane.sv
// One component lane of the vector ALU: products, rounding, element-wise results.
// Depends on vfa_pkg. Six register stages; the reflect product uses p_i at stage four.
module vfa_lane
  import vfa_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  op_t                op_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] y_i,
  input  logic signed [31:0] f_i,
  input  logic signed [31:0] c1x_i,
  input  logic signed [31:0] c1y_i,
  input  logic signed [31:0] c2x_i,
  input  logic signed [31:0] c2y_i,
  input  logic signed [31:0] p_i,
  output logic signed [64:0] rm_o,
  output logic [62:0]        sq_o,
  output logic [31:0]        res_o,
  output logic               flt_o
);

  localparam logic signed [64:0] HALF = 65'sd1 <<< (FRAC_BITS - 1);

  // Round a product with twice the fractional bits to nearest, ties upwards.
  function automatic logic signed [64:0] rnd(input logic signed [63:0] p);
    logic signed [64:0] t;
    t = 65'(p) + HALF;
    return t >>> FRAC_BITS;
  endfunction

  logic signed [31:0] ma, mb;
  sat_t               simp_nxt, res3_nxt, res6_nxt;

  op_t                op1_r, op2_r, op3_r, op4_r, op5_r;
  logic signed [31:0] x1_r, x2_r, x3_r, x4_r, x5_r;
  logic signed [31:0] y1_r, y2_r, y3_r, y4_r;
  logic signed [63:0] pm1_r, pn1_r, prod5_r;
  sat_t               simp1_r, simp2_r;
  logic signed [64:0] rm2_r, rn2_r;
  logic [62:0]        sq2_r;
  sat_t               res3_r, res4_r, res5_r, res6_r;

  // Operand selection for the main multiplier.
  always_comb begin
    ma = x_i;
    mb = y_i;
    case (op_i) inside
      OP_SCALE:                mb = f_i;
      OP_LENGTH, OP_NORMALIZE: mb = x_i;
      OP_CROSS: begin
        ma = c1x_i;
        mb = c1y_i;
      end
      default: ;
    endcase
  end

  // Element-wise operations that need no multiplier.
  always_comb begin
    case (op_i)
      OP_COPY: simp_nxt = '{flag: 1'b0, val: x_i};
      OP_ADD:  simp_nxt = sat32(sw_t'(x_i) + sw_t'(y_i));
      OP_SUB:  simp_nxt = sat32(sw_t'(x_i) - sw_t'(y_i));
      OP_MIN:  simp_nxt = '{flag: 1'b0, val: (x_i < y_i) ? x_i : y_i};
      OP_MAX:  simp_nxt = '{flag: 1'b0, val: (x_i > y_i) ? x_i : y_i};
      default: simp_nxt = '0;
    endcase
  end

  // Lane result before the reflect correction.
  always_comb begin
    case (op2_r) inside
      OP_COPY, OP_ADD, OP_SUB, OP_MIN, OP_MAX: res3_nxt = simp2_r;
      OP_SCALE: res3_nxt = sat32(sw_t'(rm2_r));
      OP_CROSS: res3_nxt = sat32(sw_t'(rm2_r) - sw_t'(rn2_r));
      default:  res3_nxt = '0;
    endcase
  end

  // Reflect subtracts the rounded p*b term from a.
  always_comb begin
    if (op5_r == OP_REFLECT) begin
      res6_nxt = sat32(sw_t'(x5_r) - sw_t'(rnd(prod5_r)));
    end else begin
      res6_nxt = res5_r;
    end
  end

  // Lane pipeline registers.
  always_ff @(posedge clk) begin
    if (en) begin
      op1_r   <= op_i;
      x1_r    <= x_i;
      y1_r    <= y_i;
      pm1_r   <= ma * mb;
      pn1_r   <= c2x_i * c2y_i;
      simp1_r <= simp_nxt;

      op2_r   <= op1_r;
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      rm2_r   <= rnd(pm1_r);
      rn2_r   <= rnd(pn1_r);
      sq2_r   <= pm1_r[62:0];
      simp2_r <= simp1_r;

      op3_r   <= op2_r;
      x3_r    <= x2_r;
      y3_r    <= y2_r;
      res3_r  <= res3_nxt;

      op4_r   <= op3_r;
      x4_r    <= x3_r;
      y4_r    <= y3_r;
      res4_r  <= res3_r;

      op5_r   <= op4_r;
      x5_r    <= x4_r;
      prod5_r <= p_i * y4_r;
      res5_r  <= res4_r;

      res6_r  <= res6_nxt;
    end
  end

  assign rm_o  = rm2_r;
  assign sq_o  = sq2_r;
  assign res_o = res6_r.val;
  assign flt_o = res6_r.flag;

endmodule

// File: src/vfa_sqrt.sv
// Pipelined integer square root of a 64-bit sum of squares, one root bit per stage.
// Depends on vfa_pkg; carries the vector word alongside the root.
module vfa_sqrt
  import vfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        v_i,
  input  pl_t         pl_i,
  input  logic [63:0] n_i,
  input  logic        ovf_i,
  output logic        v_o,
  output pl_t         pl_o,
  output logic [32:0] len_o
);

  logic [63:0] n_r   [SQRT_STEPS];
  logic [63:0] res_r [SQRT_STEPS];
  logic        ovf_r [SQRT_STEPS];
  pl_t         pl_r  [SQRT_STEPS];
  logic        v_r   [SQRT_STEPS];

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * s);
    logic [63:0] n_in, res_in;
    logic        ovf_in, v_in;
    pl_t         pl_in;
    logic [64:0] trial;

    if (s == 0) begin : g_first
      assign n_in   = n_i;
      assign res_in = '0;
      assign ovf_in = ovf_i;
      assign v_in   = v_i;
      assign pl_in  = pl_i;
    end else begin : g_next
      assign n_in   = n_r[s-1];
      assign res_in = res_r[s-1];
      assign ovf_in = ovf_r[s-1];
      assign v_in   = v_r[s-1];
      assign pl_in  = pl_r[s-1];
    end

    assign trial = {1'b0, res_in} + {1'b0, BIT};

    // One restoring step of the digit-by-digit root.
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, n_in} >= trial) begin
          n_r[s]   <= n_in - trial[63:0];
          res_r[s] <= (res_in >> 1) + BIT;
        end else begin
          n_r[s]   <= n_in;
          res_r[s] <= res_in >> 1;
        end
        ovf_r[s] <= ovf_in;
        pl_r[s]  <= pl_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end
  end

  // A sum that overflowed 64 bits has a root of exactly 2^32.
  assign len_o = ovf_r[SQRT_STEPS-1] ? {1'b1, 32'd0}
                                     : {1'b0, res_r[SQRT_STEPS-1][31:0]};
  assign v_o   = v_r[SQRT_STEPS-1];
  assign pl_o  = pl_r[SQRT_STEPS-1];

endmodule

// File: src/vfa_div.sv
// Pipelined restoring divider for normalising one component, one quotient bit per stage.
// Depends on vfa_pkg only through the shared import convention.
module vfa_div
  import vfa_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS+32:0] num_i,
  input  logic [32:0]          den_i,
  output logic [FRAC_BITS:0]   quo_o
);

  localparam int QW = FRAC_BITS + 1;
  localparam int NW = FRAC_BITS + 33;

  logic [NW-1:0] rem_r [QW];
  logic [32:0]   den_r [QW];
  logic [QW-1:0] q_r   [QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int K = QW - 1 - s;
    logic [NW-1:0] rem_in, trial;
    logic [32:0]   den_in;
    logic [QW-1:0] q_in;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign q_in   = q_r[s-1];
    end

    assign trial = NW'(den_in) << K;

    // Subtract the shifted divisor where it fits and record the bit.
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[s] <= den_in;
        if (rem_in >= trial) begin
          rem_r[s] <= rem_in - trial;
          q_r[s]   <= q_in | (QW'(1) << K);
        end else begin
          rem_r[s] <= rem_in;
          q_r[s]   <= q_in;
        end
      end
    end
  end

  assign quo_o = q_r[QW-1];

endmodule

// File: src/vec4_fixed_point_alu.sv
// Top level of the four-component signed fixed-point vector ALU.
// Depends on vfa_pkg, vfa_lane, vfa_sqrt and vfa_div.
//
// The block takes one word per clock cycle while it is not held and returns exactly
// one result word per input word, in order. Every word takes the same path whatever
// the opcode: four lanes form products and element-wise results over six stages, a
// merge stage sums the lanes for dot and length, a 32-stage root pipeline gives the
// vector length and a FRAC_BITS + 1 stage divider per lane normalises. The whole
// pipeline advances together; it holds only while a finished result sits unread in
// the output register, so in_tready follows out_tready through that register and an
// empty output slot always lets input in.
module vec4_fixed_point_alu
  import vfa_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // func[3:0], a_x[35:4], a_y[67:36], a_z[99:68], a_w[131:100], b_x[163:132],
  // b_y[195:164], b_z[227:196], b_w[259:228], factor[291:260], zero fill above
  input  logic [295:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // r_x[31:0], r_y[63:32], r_z[95:64], r_w[127:96], scalar_out[159:128],
  // fault[160], zero fill above
  output logic [167:0] out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready
);

  localparam int QW = FRAC_BITS + 1;
  localparam int NW = FRAC_BITS + 33;
  localparam logic [31:0] ONE_Q = 32'd1 << FRAC_BITS;

  typedef struct packed {
    op_t              op;
    logic [3:0][31:0] mag;
    logic [3:0]       neg;
  } fr_t;

  logic en;

  // Stage zero input registers.
  op_t                op0_r;
  logic signed [31:0] a0_r [4];
  logic signed [31:0] b0_r [4];
  logic signed [31:0] f0_r;

  // Per-item control and magnitudes carried beside the lanes.
  logic [6:0] fv_r;
  fr_t        fr_r [7];
  fr_t        fr_nxt;

  // Lane outputs.
  logic signed [64:0] lrm [4];
  logic [62:0]        lsq [4];
  logic [31:0]        lres [4];
  logic [3:0]         lflt;

  // Merge stage registers.
  sw_t         dsum3_r;
  logic [64:0] sqs3_r, sqs4_r, sqs5_r, sqs6_r;
  sat_t        d4_r, p4_r, d_nxt, p_nxt;
  logic [31:0] d5_r, d6_r;
  logic        dflt5_r, dflt6_r, rflt5_r, rflt6_r;

  pl_t         pl_nxt;
  logic        sq_v;
  pl_t         sq_pl;
  logic [32:0] sq_len;

  // Divider inputs and delayed words.
  logic [NW-1:0] dnum [4];
  logic [QW-1:0] quo  [4];
  logic [QW-1:0] vd_r;
  pl_t           pd_r [QW];
  logic [32:0]   ld_r [QW];

  logic          out_v_r;
  logic [167:0]  out_d_r, out_nxt;

  assign en        = !out_v_r || out_tready;
  assign in_tready = en;

  // Magnitudes and signs for normalise, taken straight from the input word.
  always_comb begin
    fr_nxt.op = op_t'(in_tdata[3:0]);
    for (int i = 0; i < 4; i++) begin
      fr_nxt.neg[i] = in_tdata[35 + 32 * i];
      fr_nxt.mag[i] = in_tdata[35 + 32 * i] ? (~in_tdata[4 + 32 * i +: 32] + 32'd1)
                                            : in_tdata[4 + 32 * i +: 32];
    end
  end

  // Input register and side-band pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      op0_r <= op_t'(in_tdata[3:0]);
      for (int i = 0; i < 4; i++) begin
        a0_r[i] <= in_tdata[4 + 32 * i +: 32];
        b0_r[i] <= in_tdata[132 + 32 * i +: 32];
      end
      f0_r     <= in_tdata[291:260];
      fr_r[0]  <= fr_nxt;
      for (int s = 1; s < 7; s++) begin
        fr_r[s] <= fr_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (en) begin
      fv_r <= {fv_r[5:0], in_tvalid};
    end
  end

  // Four component lanes; cross operands rotate through x, y and z.
  for (genvar i = 0; i < 4; i++) begin : g_lane
    vfa_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (en),
      .op_i  (op0_r),
      .x_i   (a0_r[i]),
      .y_i   (b0_r[i]),
      .f_i   (f0_r),
      .c1x_i (a0_r[(i + 1) % 3]),
      .c1y_i (b0_r[(i + 2) % 3]),
      .c2x_i (a0_r[(i + 2) % 3]),
      .c2y_i (b0_r[(i + 1) % 3]),
      .p_i   (p4_r.val),
      .rm_o  (lrm[i]),
      .sq_o  (lsq[i]),
      .res_o (lres[i]),
      .flt_o (lflt[i])
    );
  end

  // Clamp the dot product, then twice it for reflect.
  always_comb begin
    d_nxt = sat32(dsum3_r);
    p_nxt = sat32(sw_t'($signed(d_nxt.val)) + sw_t'($signed(d_nxt.val)));
  end

  // Merge of the lane products into the dot sum and the sum of squares.
  always_ff @(posedge clk) begin
    if (en) begin
      dsum3_r <= sw_t'(lrm[0]) + sw_t'(lrm[1]) + sw_t'(lrm[2]) + sw_t'(lrm[3]);
      sqs3_r  <= {2'b00, lsq[0]} + {2'b00, lsq[1]} + {2'b00, lsq[2]} + {2'b00, lsq[3]};
      d4_r    <= d_nxt;
      p4_r    <= p_nxt;
      sqs4_r  <= sqs3_r;
      d5_r    <= d4_r.val;
      dflt5_r <= d4_r.flag;
      rflt5_r <= d4_r.flag | p4_r.flag;
      sqs5_r  <= sqs4_r;
      d6_r    <= d5_r;
      dflt6_r <= dflt5_r;
      rflt6_r <= rflt5_r;
      sqs6_r  <= sqs5_r;
    end
  end

  // Gather the lane results into one word for the root pipeline.
  always_comb begin
    pl_nxt.op  = fr_r[6].op;
    pl_nxt.mag = fr_r[6].mag;
    pl_nxt.neg = fr_r[6].neg;
    for (int i = 0; i < 4; i++) begin
      pl_nxt.r[i] = lres[i];
    end
    if (fr_r[6].op == OP_CROSS) begin
      pl_nxt.r[3] = ONE_Q;
    end
    pl_nxt.scalar = (fr_r[6].op == OP_DOT) ? d6_r : 32'd0;
    pl_nxt.fault  = (|lflt[2:0]) | (lflt[3] & (fr_r[6].op != OP_CROSS))
                  | ((fr_r[6].op == OP_DOT) & dflt6_r)
                  | ((fr_r[6].op == OP_REFLECT) & rflt6_r);
  end

  vfa_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_i   (fv_r[6]),
    .pl_i  (pl_nxt),
    .n_i   (sqs6_r[63:0]),
    .ovf_i (sqs6_r[64]),
    .v_o   (sq_v),
    .pl_o  (sq_pl),
    .len_o (sq_len)
  );

  // Normalise: each magnitude scaled up and divided by the length, rounded.
  for (genvar i = 0; i < 4; i++) begin : g_div
    assign dnum[i] = (NW'(sq_pl.mag[i]) << FRAC_BITS) + NW'(sq_len >> 1);

    vfa_div #(
      .FRAC_BITS(FRAC_BITS)
    ) u_div (
      .clk   (clk),
      .en    (en),
      .num_i (dnum[i]),
      .den_i (sq_len),
      .quo_o (quo[i])
    );
  end

  // Word and length wait beside the dividers.
  always_ff @(posedge clk) begin
    if (en) begin
      pd_r[0] <= sq_pl;
      ld_r[0] <= sq_len;
      for (int s = 1; s < QW; s++) begin
        pd_r[s] <= pd_r[s-1];
        ld_r[s] <= ld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= '0;
    end else if (en) begin
      vd_r <= {vd_r[QW-2:0], sq_v};
    end
  end

  // Final merge of length, normalise and passed-through lane results into the output word.
  always_comb begin
    logic [31:0] q32;
    q32     = '0;
    out_nxt = '0;
    case (pd_r[QW-1].op)
      OP_LENGTH: begin
        if (ld_r[QW-1][32] || ld_r[QW-1][31]) begin
          out_nxt[159:128] = S32_MAX;
          out_nxt[160]     = 1'b1;
        end else begin
          out_nxt[159:128] = ld_r[QW-1][31:0];
        end
      end
      OP_NORMALIZE: begin
        if (ld_r[QW-1] == '0) begin
          out_nxt[160] = 1'b1;
        end else begin
          for (int i = 0; i < 4; i++) begin
            q32 = 32'(quo[i]);
            out_nxt[32 * i +: 32] = pd_r[QW-1].neg[i] ? (~q32 + 32'd1) : q32;
          end
        end
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          out_nxt[32 * i +: 32] = pd_r[QW-1].r[i];
        end
        out_nxt[159:128] = pd_r[QW-1].scalar;
        out_nxt[160]     = pd_r[QW-1].fault;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= vd_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d_r <= out_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  // A cross product leaving the pipeline always carries 1.0 in its fourth component.
  a_cross_w : assert property (@(posedge clk) disable iff (!rst_n)
      (vd_r[QW-1] && en && pd_r[QW-1].op == OP_CROSS) |=> (out_tdata[127:96] == ONE_Q))
    else $error("cross result fourth component is not 1.0");

  // The root never exceeds 2^32.
  a_len_range : assert property (@(posedge clk) disable iff (!rst_n)
      (sq_v && sq_len[32]) |-> (sq_len[31:0] == 32'd0))
    else $error("vector length beyond 2^32");

  // Scalar opcodes leave every lane result at zero.
  a_scalar_lanes : assert property (@(posedge clk) disable iff (!rst_n)
      (fv_r[6] && (fr_r[6].op == OP_DOT || fr_r[6].op == OP_LENGTH))
      |-> (lres[0] == 32'd0 && lres[1] == 32'd0 && lres[2] == 32'd0 && lres[3] == 32'd0
           && lflt == 4'd0))
    else $error("lane result not zero for a scalar opcode");

endmodule
